// ===== sv/rgci_pkg.sv =====
// Package for rotated grid cell index: shared constants.
// No dependencies.
`default_nettype none
package rgci_pkg;
  localparam int unsigned CfgAw = 5;
  localparam logic [2:0] RegOx = 3'd0, RegOy = 3'd1, RegCos = 3'd2, RegSin = 3'd3,
                         RegLx = 3'd4, RegLy = 3'd5, RegDx = 3'd6, RegDy = 3'd7;
  localparam int unsigned QW = 52;   // rotated coordinate, Q.16
  localparam int unsigned DW = 33;   // depth difference
endpackage
`default_nettype wire

// ===== sv/rgci_div_cell.sv =====
// One restoring-division cell: one quotient bit per cycle while en is high, handed onward.
// Depends on rgci_pkg.
`default_nettype none
module rgci_div_cell
  import rgci_pkg::*;
#(
  parameter int unsigned NW = 52,
  parameter int unsigned QB = 9,
  parameter int unsigned SH = 0,
  parameter int unsigned PW = 1
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] rem_i,
  input  wire logic [NW-1:0] den_i,
  input  wire logic [QB-1:0] q_i,
  input  wire logic [PW-1:0] pay_i,
  output logic      [NW-1:0] rem_o,
  output logic      [NW-1:0] den_o,
  output logic      [QB-1:0] q_o,
  output logic      [PW-1:0] pay_o
);
  logic [NW+QB:0] d_sh;
  logic           ge;
  always_comb begin
    d_sh = {{(QB+1){1'b0}}, den_i} << SH;
    ge = ({{(QB+1){1'b0}}, rem_i} >= d_sh);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= ge ? rem_i - d_sh[NW-1:0] : rem_i;
      den_o <= den_i;
      q_o   <= q_i | (QB'(ge) << SH);
      pay_o <= pay_i;
    end
  end
endmodule
`default_nettype wire

// ===== sv/rgci_div_chain.sv =====
// Chain of division cells, most significant quotient bit first.
// Depends on rgci_pkg and rgci_div_cell.
`default_nettype none
module rgci_div_chain
  import rgci_pkg::*;
#(
  parameter int unsigned NW = 52,
  parameter int unsigned QB = 9,
  parameter int unsigned PW = 1
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [NW-1:0] den_i,
  input  wire logic [PW-1:0] pay_i,
  output logic      [QB-1:0] q_o,
  output logic      [PW-1:0] pay_o
);
  logic [NW-1:0] rem [QB+1];
  logic [NW-1:0] den [QB+1];
  logic [QB-1:0] q   [QB+1];
  logic [PW-1:0] pay [QB+1];
  assign rem[0] = num_i;
  assign den[0] = den_i;
  assign q[0]   = '0;
  assign pay[0] = pay_i;
  for (genvar g = 0; g < QB; g++) begin : g_cell
    rgci_div_cell #(.NW(NW), .QB(QB), .SH(QB-1-g), .PW(PW)) u_cell (
      .clk, .en, .rem_i(rem[g]), .den_i(den[g]), .q_i(q[g]), .pay_i(pay[g]),
      .rem_o(rem[g+1]), .den_o(den[g+1]), .q_o(q[g+1]), .pay_o(pay[g+1]));
  end
  assign q_o   = q[QB];
  assign pay_o = pay[QB];
endmodule
`default_nettype wire

// ===== sv/rotated_grid_cell_index.sv =====
// Rotated grid cell index: top level, config registers, front end, output.
// Depends on rgci_pkg, rgci_div_chain.
// One transaction per clock while the output is not stalled, fully pipelined:
// the front stages (differences, products, rotation), then one cell per
// quotient bit in the divider chains (every chain is built with the widest
// quotient needed, the layer divider of clog2(GRID_NZ)+1 bits or the cell
// chains of clog2(max(GRID_NX,GRID_NY))+1 bits), then the output register:
// thirteen register stages at the default sizes. The whole pipe advances
// together; it holds while the output is stalled and full, so nothing is
// lost, and in_stall follows that condition in the same cycle. Zero cell
// sizes saturate to the last cell.
`default_nettype none
module rotated_grid_cell_index
  import rgci_pkg::*;
#(
  parameter int unsigned GRID_NX = 256,
  parameter int unsigned GRID_NY = 256,
  parameter int unsigned GRID_NZ = 128
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [CfgAw-1:0]   cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic      [31:0]        cfg_prdata,
  output logic                    cfg_pready,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  input  wire logic signed [31:0] in_top_depth,
  input  wire logic signed [31:0] in_bottom_depth,
  input  wire logic               in_top_absent,
  input  wire logic               in_bottom_absent,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_found,
  output logic      [22:0]        out_linear_index,
  output logic      [7:0]         out_col_index,
  output logic      [7:0]         out_row_index,
  output logic      [6:0]         out_layer_index
);
  localparam int unsigned XB = $clog2(GRID_NX) + 1;
  localparam int unsigned YB = $clog2(GRID_NY) + 1;
  localparam int unsigned ZB = $clog2(GRID_NZ) + 1;
  localparam int unsigned MB = (XB > YB) ? ((XB > ZB) ? XB : ZB) : ((YB > ZB) ? YB : ZB);
  localparam int unsigned LAT = MB;

  // ---------------- configuration registers
  logic signed [31:0] ox_r, oy_r;
  logic signed [17:0] cos_r, sin_r;
  logic [30:0] lx_r, ly_r, cdx_r, cdy_r;
  logic [2:0]  ridx;
  logic        wr;
  assign ridx = cfg_paddr[4:2];
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ox_r <= '0; oy_r <= '0; cos_r <= 18'sd65536; sin_r <= '0;
      lx_r <= 31'd65536; ly_r <= 31'd65536; cdx_r <= 31'd256; cdy_r <= 31'd256;
    end else if (wr) begin
      unique case (ridx)
        RegOx:  ox_r  <= cfg_pwdata;
        RegOy:  oy_r  <= cfg_pwdata;
        RegCos: cos_r <= cfg_pwdata[17:0];
        RegSin: sin_r <= cfg_pwdata[17:0];
        RegLx:  lx_r  <= cfg_pwdata[30:0];
        RegLy:  ly_r  <= cfg_pwdata[30:0];
        RegDx:  cdx_r <= cfg_pwdata[30:0];
        default: cdy_r <= cfg_pwdata[30:0];
      endcase
    end
  end
  always_comb begin
    unique case (ridx)
      RegOx:  cfg_prdata = ox_r;
      RegOy:  cfg_prdata = oy_r;
      RegCos: cfg_prdata = {{14{cos_r[17]}}, cos_r};
      RegSin: cfg_prdata = {{14{sin_r[17]}}, sin_r};
      RegLx:  cfg_prdata = {1'b0, lx_r};
      RegLy:  cfg_prdata = {1'b0, ly_r};
      RegDx:  cfg_prdata = {1'b0, cdx_r};
      default: cfg_prdata = {1'b0, cdy_r};
    endcase
  end

  // ---------------- pipe enable: advance unless the output is full and stalled
  logic en;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: differences and depth checks
  logic        v1_r;
  logic signed [32:0] dx1_r, dy1_r, dz1_r, dd1_r;
  logic        dok1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_valid;
    if (en) begin
      dx1_r <= 33'(in_pos_x) - 33'(ox_r);
      dy1_r <= 33'(in_pos_y) - 33'(oy_r);
      dz1_r <= 33'(in_pos_z) - 33'(in_top_depth);
      dd1_r <= 33'(in_bottom_depth) - 33'(in_top_depth);
      dok1_r <= !in_top_absent && !in_bottom_absent &&
                (in_pos_z > in_top_depth) && (in_pos_z < in_bottom_depth);
    end
  end

  // stage 2: four products
  logic v2_r, dok2_r;
  logic signed [50:0] xc2_r, ys2_r, yc2_r, xs2_r;
  logic [DW-1:0] dz2_r, dd2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
    if (en) begin
      xc2_r <= dx1_r * cos_r; ys2_r <= dy1_r * sin_r;
      yc2_r <= dy1_r * cos_r; xs2_r <= dx1_r * sin_r;
      dz2_r <= dz1_r; dd2_r <= dd1_r; dok2_r <= dok1_r;
    end
  end

  // stage 3: rotate and test the rectangle
  logic v3_r, ok3_r;
  logic [QW-1:0] rx3_r, ry3_r, nz3_r, dd3_r;
  logic signed [QW-1:0] rx_c, ry_c;
  always_comb begin
    rx_c = QW'(xc2_r) + QW'(ys2_r);
    ry_c = QW'(yc2_r) - QW'(xs2_r);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
    if (en) begin
      rx3_r <= rx_c; ry3_r <= ry_c;
      ok3_r <= dok2_r && !rx_c[QW-1] && !ry_c[QW-1] &&
               (rx_c <= $signed({5'd0, lx_r, 16'd0})) &&
               (ry_c <= $signed({5'd0, ly_r, 16'd0}));
      // layer numerator: depth offset scaled by the layer count (constant)
      nz3_r <= QW'(dz2_r) * QW'(GRID_NZ);
      dd3_r <= QW'(dd2_r);
    end
  end

  // divider chains (zero cell size handled by saturation: divisor 0 gives all ones)
  // each chain carries the hit flag beside its quotient
  logic [MB-1:0] qxm, qym, qzm;
  logic          okx, oky, okz, okq;
  rgci_div_chain #(.NW(QW), .QB(MB), .PW(1)) u_cx (
    .clk, .en, .num_i(rx3_r), .den_i({5'd0, cdx_r, 16'd0}), .pay_i(ok3_r),
    .q_o(qxm), .pay_o(okx));
  rgci_div_chain #(.NW(QW), .QB(MB), .PW(1)) u_cy (
    .clk, .en, .num_i(ry3_r), .den_i({5'd0, cdy_r, 16'd0}), .pay_i(ok3_r),
    .q_o(qym), .pay_o(oky));
  rgci_div_chain #(.NW(QW), .QB(MB), .PW(1)) u_cz (
    .clk, .en, .num_i(nz3_r), .den_i(dd3_r), .pay_i(ok3_r),
    .q_o(qzm), .pay_o(okz));
  assign okq = okx && oky && okz;

  // valid through the chain needs reset: track it separately
  logic [LAT-1:0] vsh_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vsh_r <= '0;
    else if (en) vsh_r <= LAT'({vsh_r, v3_r});
  end

  // output: saturate, combine
  logic [31:0] col_c, row_c, lay_c, lin_c;
  always_comb begin
    col_c = (qxm >= MB'(GRID_NX - 1)) ? 32'(GRID_NX - 1) : 32'(qxm);
    row_c = (qym >= MB'(GRID_NY - 1)) ? 32'(GRID_NY - 1) : 32'(qym);
    lay_c = 32'(qzm);
    lin_c = col_c + row_c * 32'(GRID_NX) + lay_c * 32'(GRID_NX * GRID_NY);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (en) out_valid <= vsh_r[LAT-1];
    if (en) begin
      out_found        <= okq;
      out_linear_index <= okq ? lin_c[22:0] : '0;
      out_col_index    <= okq ? col_c[7:0] : '0;
      out_row_index    <= okq ? row_c[7:0] : '0;
      out_layer_index  <= okq ? lay_c[6:0] : '0;
    end
  end

`ifndef SYNTHESIS
  a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_linear_index == '0) else $error("nf idx");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("lost");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall) else $error("stall");
`endif
endmodule
`default_nettype wire
